// File: hdl/fec_group_receive_tracker_macros.svh
// assertion macros for the fec group receive tracker
// no dependencies; included by files that carry concurrent assertions
`ifndef FEC_GROUP_RECEIVE_TRACKER_MACROS_SVH
`define FEC_GROUP_RECEIVE_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
// property checked every clock, suspended during reset
`define FGRT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked every clock, also during reset
`define FGRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FGRT_ASSERT(lbl, clk, rst, prop, msg)
`define FGRT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hdl/fgrt_pkg.sv
// shared types and constants for the fec group receive tracker
// no dependencies
`default_nettype none
package fgrt_pkg;

  localparam int unsigned DATA_PACKETS_DEF  = 16;
  localparam int unsigned CHECK_PACKETS_DEF = 4;
  localparam int unsigned HISTORY_DEPTH_DEF = 1024;

  localparam logic [10:0] MIN_PAYLOAD   = 11'd20;
  localparam logic [31:0] TIMEOUT_RESET = 32'd10800;

  typedef enum logic [2:0] {
    ACT_DELIVER = 3'd0,
    ACT_DECODE  = 3'd1,
    ACT_ABSORB  = 3'd2,
    ACT_SHORT   = 3'd3,
    ACT_AUTH    = 3'd4,
    ACT_LATE    = 3'd5,
    ACT_DUP     = 3'd6
  } action_t;

  typedef struct packed {
    logic [31:0] seq_number;
    logic [10:0] payload_len;
    logic        auth_ok;
    logic [31:0] now_seconds;
    logic        force_resync;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  group_index;
    logic [10:0] decode_len;
    logic        resynced;
    logic [31:0] total_packets;
    logic [31:0] recovered_groups;
    logic [31:0] lost_packets;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SWEEP_ALL,
    S_RESYNC,
    S_ORDER,
    S_SWEEP_WALK,
    S_READ,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    check;
    logic    sweep_all;
    logic    sweep_walk;
    logic    sweep_run;
    logic    resync_commit;
    logic    order;
    logic    advance;
    logic    read_slot;
    logic    update;
    logic    fin_valid;
    action_t fin_code;
    logic    clear_run;
  } cmd_t;

  typedef struct packed {
    logic is_short;
    logic auth_fail;
    logic need_resync;
    logic late;
    logic ahead;
    logic sweep_done;
    logic clear_done;
  } stat_t;

endpackage
`default_nettype wire

// File: hdl/fgrt_ctrl.sv
// controller state machine of the fec group receive tracker
// depends on fgrt_pkg and the assertion macro header
`default_nettype none
`include "fec_group_receive_tracker_macros.svh"
module fgrt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  output fgrt_pkg::cmd_t      cmd,
  input  fgrt_pkg::stat_t     stat
);
  import fgrt_pkg::*;

  state_t state, state_next;
  logic   fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:      if (stat.clear_done) state_next = S_IDLE;
      S_IDLE:       if (start) state_next = S_CHECK;
      S_CHECK: begin
        if (stat.is_short || stat.auth_fail) state_next = S_IDLE;
        else if (stat.need_resync) state_next = S_SWEEP_ALL;
        else state_next = S_ORDER;
      end
      S_SWEEP_ALL:  if (stat.sweep_done) state_next = S_RESYNC;
      S_RESYNC:     state_next = S_ORDER;
      S_ORDER: begin
        if (stat.late) state_next = S_IDLE;
        else if (stat.ahead) state_next = S_SWEEP_WALK;
        else state_next = S_READ;
      end
      S_SWEEP_WALK: if (stat.sweep_done) state_next = S_READ;
      S_READ:       state_next = S_UPDATE;
      S_UPDATE:     state_next = S_IDLE;
      default:      state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.fin_code = ACT_DELIVER;
    busy = 1'b1;
    case (state)
      S_CLEAR: cmd.clear_run = 1'b1;
      S_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      S_CHECK: begin
        if (stat.is_short) begin
          cmd.fin_valid = 1'b1;
          cmd.fin_code  = ACT_SHORT;
        end else begin
          cmd.check = 1'b1;
          if (stat.auth_fail) begin
            cmd.fin_valid = 1'b1;
            cmd.fin_code  = ACT_AUTH;
          end else if (stat.need_resync) begin
            cmd.sweep_all = 1'b1;
          end
        end
      end
      S_SWEEP_ALL: cmd.sweep_run = 1'b1;
      S_RESYNC:    cmd.resync_commit = 1'b1;
      S_ORDER: begin
        cmd.order = 1'b1;
        if (stat.late) begin
          cmd.fin_valid = 1'b1;
          cmd.fin_code  = ACT_LATE;
        end else if (stat.ahead) begin
          cmd.sweep_walk = 1'b1;
        end
      end
      S_SWEEP_WALK: begin
        cmd.sweep_run = 1'b1;
        cmd.advance   = stat.sweep_done;
      end
      S_READ:   cmd.read_slot = 1'b1;
      S_UPDATE: cmd.update = 1'b1;
      default:  cmd = '0;
    endcase
  end

  assign fin = cmd.fin_valid || cmd.update;

  `FGRT_ASSERT(a_update_after_read, clk, rst, state == S_UPDATE |-> $past(state) == S_READ, "update without slot read")
  `FGRT_ASSERT(a_resync_to_order, clk, rst, state == S_RESYNC |=> state == S_ORDER, "resync not followed by order check")
  `FGRT_ASSERT(a_finish_idle, clk, rst, fin |=> state == S_IDLE, "result finished but not idle")

endmodule
`default_nettype wire

// File: hdl/fgrt_dp.sv
// datapath of the fec group receive tracker: history memory, counters, result
// depends on fgrt_pkg
`default_nettype none
module fgrt_dp #(
  parameter int unsigned DATA_PACKETS  = fgrt_pkg::DATA_PACKETS_DEF,
  parameter int unsigned CHECK_PACKETS = fgrt_pkg::CHECK_PACKETS_DEF,
  parameter int unsigned HISTORY_DEPTH = fgrt_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  fgrt_pkg::in_t       item,
  input  wire logic           cfg_valid,
  input  wire logic [31:0]    cfg_data,
  input  fgrt_pkg::cmd_t      cmd,
  output fgrt_pkg::stat_t     stat,
  output fgrt_pkg::out_t      result,
  output logic                result_valid
);
  import fgrt_pkg::*;

  localparam int unsigned GROUP_TOTAL = DATA_PACKETS + CHECK_PACKETS;
  localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W = $clog2(GROUP_TOTAL + 1);
  localparam int unsigned ENT_W = CNT_W + 11;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [31:0] DEPTH32 = 32'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] DATA_C = CNT_W'(DATA_PACKETS);
  localparam logic [CNT_W-1:0] TOTAL_C = CNT_W'(GROUP_TOTAL);

  in_t         pkt;
  logic [31:0] timeout;
  logic [31:0] newest_seq, first_seq, last_time;
  logic [31:0] total_count, recovered_count, lost_count;
  logic [31:0] snap_total, snap_rec, snap_lost;
  logic        resynced;

  logic [ENT_W-1:0] mem [HISTORY_DEPTH];
  logic [ENT_W-1:0] mem_q;
  logic [IDX_W-1:0] rd_addr, last_addr, wr_addr, clr_addr;
  logic             pend, pend_last, iss_done;

  logic [IDX_W-1:0] slot, mem_ra, mem_wa;
  logic             mem_we;
  logic [ENT_W-1:0] mem_wd;
  logic             issue;

  logic [CNT_W-1:0] q_cnt, cnt_inc;
  logic [10:0]      q_len, new_len;
  logic [31:0]      add_total, add_lost;
  logic             add_rec;
  action_t          upd_act;
  logic             upd_we;
  logic [31:0]      d_ahead, d_far, d_late, elapsed;

  assign slot = pkt.seq_number[IDX_W-1:0];

  // serial order checks against the window
  assign d_ahead = pkt.seq_number - newest_seq;
  assign d_far   = pkt.seq_number - (newest_seq + DEPTH32 - 32'd1);
  assign d_late  = newest_seq - DEPTH32 - pkt.seq_number;
  assign elapsed = pkt.now_seconds - last_time;

  always_comb begin
    stat.is_short    = pkt.payload_len < MIN_PAYLOAD;
    stat.auth_fail   = !pkt.auth_ok;
    stat.need_resync = pkt.force_resync || (elapsed > timeout) ||
                       (!d_far[31] && d_far != 32'd0);
    stat.late        = !d_late[31];
    stat.ahead       = !d_ahead[31] && d_ahead != 32'd0;
    stat.sweep_done  = pend && pend_last;
    stat.clear_done  = clr_addr == LAST_IDX;
  end

  // recycle one slot read by the sweep
  assign q_cnt = mem_q[ENT_W-1:11];
  assign q_len = mem_q[10:0];
  always_comb begin
    add_total = 32'd0;
    add_lost  = 32'd0;
    add_rec   = 1'b0;
    if (q_cnt != '0) begin
      if (q_cnt >= DATA_C) begin
        add_total = 32'(DATA_PACKETS);
        add_rec   = q_cnt < TOTAL_C;
      end else begin
        add_total = 32'(q_cnt);
        if (wr_addr != newest_seq[IDX_W-1:0] && wr_addr != first_seq[IDX_W-1:0])
          add_lost = 32'(DATA_PACKETS) - 32'(q_cnt);
      end
    end
  end

  // count the packet in its group
  assign cnt_inc = q_cnt + CNT_W'(1);
  always_comb begin
    new_len = q_len;
    upd_we  = 1'b1;
    if (q_cnt >= TOTAL_C) begin
      upd_act = ACT_DUP;
      upd_we  = 1'b0;
    end else if (cnt_inc > DATA_C) begin
      upd_act = ACT_ABSORB;
    end else begin
      if (pkt.payload_len > q_len) new_len = pkt.payload_len;
      upd_act = (cnt_inc == DATA_C) ? ACT_DECODE : ACT_DELIVER;
    end
  end

  assign issue = cmd.sweep_run && !iss_done;

  always_comb begin
    mem_ra = cmd.sweep_run ? rd_addr : slot;
    mem_we = 1'b0;
    mem_wa = slot;
    mem_wd = '0;
    if (cmd.clear_run) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
    end else if (cmd.sweep_run && pend) begin
      mem_we = 1'b1;
      mem_wa = wr_addr;
    end else if (cmd.update) begin
      mem_we = upd_we;
      mem_wd = {cnt_inc, new_len};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  // sweep address pipeline: read one slot a cycle, zero it the next
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
      iss_done  <= 1'b1;
    end else begin
      if (cmd.clear_run) clr_addr <= clr_addr + IDX_W'(1);
      if (cmd.sweep_all || cmd.sweep_walk) begin
        pend     <= 1'b0;
        iss_done <= 1'b0;
      end else if (cmd.sweep_run) begin
        pend <= issue;
        if (issue) begin
          pend_last <= rd_addr == last_addr;
          iss_done  <= rd_addr == last_addr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_all) begin
      rd_addr   <= '0;
      last_addr <= LAST_IDX;
    end else if (cmd.sweep_walk) begin
      rd_addr   <= newest_seq[IDX_W-1:0] + IDX_W'(1);
      last_addr <= slot;
    end else if (issue) begin
      rd_addr <= rd_addr + IDX_W'(1);
      wr_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) pkt <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout         <= TIMEOUT_RESET;
      newest_seq      <= '0;
      first_seq       <= '0;
      last_time       <= '0;
      total_count     <= '0;
      recovered_count <= '0;
      lost_count      <= '0;
      resynced        <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_valid) timeout <= cfg_data;
      if (cmd.load) resynced <= 1'b0;
      if (cmd.check && first_seq == 32'd0) first_seq <= pkt.seq_number;
      if (cmd.order) last_time <= pkt.now_seconds;
      if (cmd.advance) newest_seq <= pkt.seq_number;
      if (cmd.resync_commit) begin
        resynced        <= 1'b1;
        newest_seq      <= pkt.seq_number;
        first_seq       <= pkt.seq_number;
        total_count     <= '0;
        recovered_count <= '0;
        lost_count      <= '0;
      end else if (cmd.sweep_run && pend) begin
        total_count     <= total_count + add_total;
        recovered_count <= recovered_count + 32'(add_rec);
        lost_count      <= lost_count + add_lost;
      end
      result_valid <= cmd.fin_valid || cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resync_commit) begin
      snap_total <= total_count;
      snap_rec   <= recovered_count;
      snap_lost  <= lost_count;
    end
    if (cmd.fin_valid || cmd.update) begin
      result.action      <= cmd.update ? upd_act : cmd.fin_code;
      result.group_index <= 10'(pkt.seq_number & (DEPTH32 - 32'd1));
      result.decode_len  <= (cmd.update && upd_act == ACT_DECODE) ? new_len : 11'd0;
      result.resynced    <= resynced;
      result.total_packets    <= resynced ? snap_total : total_count;
      result.recovered_groups <= resynced ? snap_rec : recovered_count;
      result.lost_packets     <= resynced ? snap_lost : lost_count;
    end
  end

endmodule
`default_nettype wire

// File: hdl/fec_group_receive_tracker.sv
// top level of the fec group receive tracker: controller plus datapath
// depends on fgrt_pkg, fgrt_ctrl and fgrt_dp
// a packet that moves the window forward adds a sweep of the skipped slots, a resync a sweep of the whole table
// one packet at a time: start is taken only in idle, while busy is low
// reset: the history table is zeroed by a clearing pass over every slot, busy held high
// results are strobed for one cycle and cannot be stalled
`default_nettype none
module fec_group_receive_tracker #(
  parameter int unsigned DATA_PACKETS  = fgrt_pkg::DATA_PACKETS_DEF,
  parameter int unsigned CHECK_PACKETS = fgrt_pkg::CHECK_PACKETS_DEF,
  // must be a power of two
  parameter int unsigned HISTORY_DEPTH = fgrt_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  fgrt_pkg::in_t     item,
  output fgrt_pkg::out_t    result,
  output logic              result_valid,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [31:0]  cfg_data
);
  import fgrt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // timeout register takes a beat in any cycle
  assign cfg_ready = 1'b1;

  // sequencing of checks, sweeps and the slot update
  fgrt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // history memory, window registers and counters
  fgrt_dp #(
    .DATA_PACKETS  (DATA_PACKETS),
    .CHECK_PACKETS (CHECK_PACKETS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
`default_nettype wire
